[rtl/core/c25519sq_pkg.sv]
// ----------------------------------------------------------------------------
// c25519sq_pkg
// Widths, types and product tables shared by the GF(2^255-19) squarer.
// ----------------------------------------------------------------------------
package c25519sq_pkg;

    // Limb geometry in radix 2^51 with the loose 52-bit input bound.
    localparam int LIMB_W    = 51;
    localparam int IN_W      = 52;
    localparam int NUM_LIMBS = 5;

    // A 52x52 product is built from four 26x26 partial products.
    localparam int HALF_W = IN_W / 2;
    localparam int PP_W   = 2 * HALF_W;
    localparam int PROD_W = 2 * IN_W;

    // Column sums stay below 2^112; the top carry and the folded limb 0.
    localparam int COL_W  = 112;
    localparam int TOP_W  = COL_W - LIMB_W;
    localparam int T0_W   = TOP_W + 5;

    // Pipeline depth of the whole squarer.
    localparam int NUM_STG = 10;

    typedef logic [IN_W-1:0]   t_in_limb;
    typedef logic [LIMB_W-1:0] t_limb;
    typedef logic [PP_W-1:0]   t_pp;
    typedef logic [PROD_W-1:0] t_prod;
    typedef logic [COL_W-1:0]  t_col;
    typedef logic [2:0]        t_lidx;

    // Load enables of the two multiplier stages.
    typedef struct packed {
        logic load_pp;
        logic load_prod;
    } t_mul_en;

    // The fifteen distinct limb products of the square.
    localparam int NUM_PROD = 15;
    localparam int P00 = 0;
    localparam int P11 = 1;
    localparam int P22 = 2;
    localparam int P33 = 3;
    localparam int P44 = 4;
    localparam int P01 = 5;
    localparam int P02 = 6;
    localparam int P03 = 7;
    localparam int P04 = 8;
    localparam int P12 = 9;
    localparam int P13 = 10;
    localparam int P14 = 11;
    localparam int P23 = 12;
    localparam int P24 = 13;
    localparam int P34 = 14;

    localparam t_lidx PAIR_A [NUM_PROD] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd0, 3'd0,
        3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3
    };
    localparam t_lidx PAIR_B [NUM_PROD] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd1, 3'd2, 3'd3,
        3'd4, 3'd2, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4
    };

endpackage

[rtl/core/c25519sq_if.sv]
// ----------------------------------------------------------------------------
// c25519sq interfaces
// Valid/ready channels for the squarer operand and result words.
// ----------------------------------------------------------------------------

// Operand channel: five input limbs.
interface c25519sq_in_if import c25519sq_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_limb limb_in0;
    t_in_limb limb_in1;
    t_in_limb limb_in2;
    t_in_limb limb_in3;
    t_in_limb limb_in4;

    modport source (
        output valid, limb_in0, limb_in1, limb_in2, limb_in3, limb_in4,
        input  ready
    );
    modport sink (
        input  valid, limb_in0, limb_in1, limb_in2, limb_in3, limb_in4,
        output ready
    );
endinterface

// Result channel: five result limbs, limb 2 one bit wider.
interface c25519sq_out_if import c25519sq_pkg::*; ();
    logic     valid;
    logic     ready;
    t_limb    limb_out0;
    t_limb    limb_out1;
    t_in_limb limb_out2;
    t_limb    limb_out3;
    t_limb    limb_out4;

    modport source (
        output valid, limb_out0, limb_out1, limb_out2, limb_out3, limb_out4,
        input  ready
    );
    modport sink (
        input  valid, limb_out0, limb_out1, limb_out2, limb_out3, limb_out4,
        output ready
    );
endinterface

[rtl/core/curve25519_field_square_top.sv]
// ----------------------------------------------------------------------------
// curve25519_field_square_top
// Pipelined squarer for GF(2^255-19) elements in five radix-2^51 limbs.
// ----------------------------------------------------------------------------
// The squarer takes one operand word per clock while the result side does
// not stall, and returns its square, one result word per operand, in the
// same order. The ten register stages are two for the 26x26 partial
// products and their assembly into the fifteen limb products, two for the
// doubled and 19-folded column sums, four for the serial carry chain
// through the columns, one for folding the top carry back into limb 0, and
// one for the final two-limb carry into the output register. Each stage has
// its own valid bit and takes a new word whenever it is empty or its
// successor moves, so bubbles close up while the result side stalls. Outputs
// keep 51 bits per limb except limb 2, which may be exactly 2^51. There is
// no state besides the pipeline itself.
// ----------------------------------------------------------------------------
module curve25519_field_square_top import c25519sq_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    c25519sq_in_if.sink   i_in,
    c25519sq_out_if.source o_out
);

    // Stage indexes of the pipeline, for the load enables.
    localparam int S_PP   = 0;
    localparam int S_PROD = 1;
    localparam int S_XY   = 2;
    localparam int S_COL  = 3;
    localparam int S_CY1  = 4;
    localparam int S_CY2  = 5;
    localparam int S_CY3  = 6;
    localparam int S_CY4  = 7;
    localparam int S_FOLD = 8;
    localparam int S_OUT  = 9;

    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG:0]   w_rdy;
    logic [NUM_STG-1:0] w_vld_in;

    t_in_limb w_limb [NUM_LIMBS];
    t_prod    w_prod [NUM_PROD];
    t_mul_en  w_mul_en;

    t_col r_x [NUM_LIMBS];
    t_col r_y [NUM_LIMBS-1];
    t_col r_c [NUM_LIMBS];

    t_limb r5_lo0;
    t_col  r5_c1, r5_c2, r5_c3, r5_c4;
    t_limb r6_lo0, r6_lo1;
    t_col  r6_c2, r6_c3, r6_c4;
    t_limb r7_lo0, r7_lo1, r7_lo2;
    t_col  r7_c3, r7_c4;
    t_limb r8_lo0, r8_lo1, r8_lo2, r8_lo3;
    t_col  r8_c4;
    t_limb r9_lo1, r9_lo2, r9_lo3, r9_lo4;
    logic [T0_W-1:0] r9_t0;
    t_limb    r_out0, r_out1, r_out3, r_out4;
    t_in_limb r_out2;

    logic [TOP_W-1:0] w_top;
    logic [T0_W-1:0]  w_top_x;
    t_in_limb         w_t1;

    function automatic t_col ext(input t_prod p);
        ext = COL_W'(p);
    endfunction

    // Handshake: a stage loads when it is empty or its successor moves.
    always_comb begin
        w_rdy[NUM_STG] = o_out.ready;
        for (int k = NUM_STG - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign w_vld_in = {r_vld[NUM_STG-2:0], i_in.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_vld_in[k];
                end
            end
        end
    end

    assign i_in.ready  = w_rdy[0];
    assign o_out.valid = r_vld[S_OUT];

    // Limb products, two stages inside each multiplier.
    assign w_limb[0] = i_in.limb_in0;
    assign w_limb[1] = i_in.limb_in1;
    assign w_limb[2] = i_in.limb_in2;
    assign w_limb[3] = i_in.limb_in3;
    assign w_limb[4] = i_in.limb_in4;

    assign w_mul_en.load_pp   = w_rdy[S_PP];
    assign w_mul_en.load_prod = w_rdy[S_PROD];

    for (genvar g = 0; g < NUM_PROD; g++) begin : g_mul
        c25519sq_mul52 u_mul (
            .i_clk (i_clk),
            .i_en  (w_mul_en),
            .i_a   (w_limb[PAIR_A[g]]),
            .i_b   (w_limb[PAIR_B[g]]),
            .o_p   (w_prod[g])
        );
    end

    // Column sums split as X + 19*Y, with the cross terms doubled.
    always_ff @(posedge i_clk) begin
        if (w_rdy[S_XY]) begin
            r_x[0] <= ext(w_prod[P00]);
            r_y[0] <= (ext(w_prod[P14]) + ext(w_prod[P23])) << 1;
            r_x[1] <= ext(w_prod[P01]) << 1;
            r_y[1] <= (ext(w_prod[P24]) << 1) + ext(w_prod[P33]);
            r_x[2] <= (ext(w_prod[P02]) << 1) + ext(w_prod[P11]);
            r_y[2] <= ext(w_prod[P34]) << 1;
            r_x[3] <= (ext(w_prod[P03]) + ext(w_prod[P12])) << 1;
            r_y[3] <= ext(w_prod[P44]);
            r_x[4] <= ((ext(w_prod[P04]) + ext(w_prod[P13])) << 1) + ext(w_prod[P22]);
        end
    end

    // Fold the high columns back: times 19 as 16 + 2 + 1.
    always_ff @(posedge i_clk) begin
        if (w_rdy[S_COL]) begin
            for (int j = 0; j < NUM_LIMBS - 1; j++) begin
                r_c[j] <= r_x[j] + (r_y[j] << 4) + (r_y[j] << 1) + r_y[j];
            end
            r_c[4] <= r_x[4];
        end
    end

    // Carry chain, one column per stage.
    always_ff @(posedge i_clk) begin
        if (w_rdy[S_CY1]) begin
            r5_lo0 <= r_c[0][LIMB_W-1:0];
            r5_c1  <= r_c[1] + (r_c[0] >> LIMB_W);
            r5_c2  <= r_c[2];
            r5_c3  <= r_c[3];
            r5_c4  <= r_c[4];
        end
        if (w_rdy[S_CY2]) begin
            r6_lo0 <= r5_lo0;
            r6_lo1 <= r5_c1[LIMB_W-1:0];
            r6_c2  <= r5_c2 + (r5_c1 >> LIMB_W);
            r6_c3  <= r5_c3;
            r6_c4  <= r5_c4;
        end
        if (w_rdy[S_CY3]) begin
            r7_lo0 <= r6_lo0;
            r7_lo1 <= r6_lo1;
            r7_lo2 <= r6_c2[LIMB_W-1:0];
            r7_c3  <= r6_c3 + (r6_c2 >> LIMB_W);
            r7_c4  <= r6_c4;
        end
        if (w_rdy[S_CY4]) begin
            r8_lo0 <= r7_lo0;
            r8_lo1 <= r7_lo1;
            r8_lo2 <= r7_lo2;
            r8_lo3 <= r7_c3[LIMB_W-1:0];
            r8_c4  <= r7_c4 + (r7_c3 >> LIMB_W);
        end
    end

    // The carry out of limb 4 wraps around into limb 0 times 19.
    assign w_top   = r8_c4[COL_W-1:LIMB_W];
    assign w_top_x = T0_W'(w_top);

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_FOLD]) begin
            r9_lo1 <= r8_lo1;
            r9_lo2 <= r8_lo2;
            r9_lo3 <= r8_lo3;
            r9_lo4 <= r8_c4[LIMB_W-1:0];
            r9_t0  <= (w_top_x << 4) + (w_top_x << 1) + w_top_x + T0_W'(r8_lo0);
        end
    end

    // Final carry from limb 0 through limb 1 into limb 2.
    assign w_t1 = IN_W'(r9_t0[T0_W-1:LIMB_W]) + IN_W'(r9_lo1);

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_OUT]) begin
            r_out0 <= r9_t0[LIMB_W-1:0];
            r_out1 <= w_t1[LIMB_W-1:0];
            r_out2 <= IN_W'(w_t1[LIMB_W]) + IN_W'(r9_lo2);
            r_out3 <= r9_lo3;
            r_out4 <= r9_lo4;
        end
    end

    assign o_out.limb_out0 = r_out0;
    assign o_out.limb_out1 = r_out1;
    assign o_out.limb_out2 = r_out2;
    assign o_out.limb_out3 = r_out3;
    assign o_out.limb_out4 = r_out4;

`ifndef NO_ASSERTIONS
    // A stalled stage keeps its word.
    for (genvar k = 0; k < NUM_STG; k++) begin : g_hold
        a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_vld[k] && !w_rdy[k] |=> r_vld[k])
            else $error("pipeline stage dropped a stalled word");
    end

    // A free result side never blocks the operand side.
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.ready |-> i_in.ready)
        else $error("operand ready low while result side is free");

    // Limb 2 carries at most one unit of excess.
    a_limb2_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.limb_out2[LIMB_W] |-> o_out.limb_out2[LIMB_W-1:0] == '0)
        else $error("result limb 2 exceeds 2^51");

    // A result only comes from the fold stage or stays from before.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[S_OUT] |-> $past(r_vld[S_FOLD]) || $past(r_vld[S_OUT]))
        else $error("result word appeared without a source");
`endif

endmodule

[rtl/core/c25519sq_mul52.sv]
// ----------------------------------------------------------------------------
// c25519sq_mul52
// Two-stage 52x52 unsigned multiplier built from four 26x26 partial products.
// ----------------------------------------------------------------------------
module c25519sq_mul52 import c25519sq_pkg::*; (
    input  logic     i_clk,
    input  t_mul_en  i_en,
    input  t_in_limb i_a,
    input  t_in_limb i_b,
    output t_prod    o_p
);

    logic [HALF_W-1:0] w_a_lo, w_a_hi, w_b_lo, w_b_hi;
    t_pp   r_pp_ll, r_pp_lh, r_pp_hl, r_pp_hh;
    t_prod r_prod;

    assign w_a_lo = i_a[HALF_W-1:0];
    assign w_a_hi = i_a[IN_W-1:HALF_W];
    assign w_b_lo = i_b[HALF_W-1:0];
    assign w_b_hi = i_b[IN_W-1:HALF_W];

    // First stage: the four half-width partial products.
    always_ff @(posedge i_clk) begin
        if (i_en.load_pp) begin
            r_pp_ll <= PP_W'(w_a_lo) * PP_W'(w_b_lo);
            r_pp_lh <= PP_W'(w_a_lo) * PP_W'(w_b_hi);
            r_pp_hl <= PP_W'(w_a_hi) * PP_W'(w_b_lo);
            r_pp_hh <= PP_W'(w_a_hi) * PP_W'(w_b_hi);
        end
    end

    // Second stage: shift the partial products into place and sum them.
    always_ff @(posedge i_clk) begin
        if (i_en.load_prod) begin
            r_prod <= PROD_W'(r_pp_ll)
                    + (PROD_W'(r_pp_lh) << HALF_W)
                    + (PROD_W'(r_pp_hl) << HALF_W)
                    + (PROD_W'(r_pp_hh) << IN_W);
        end
    end

    assign o_p = r_prod;

endmodule

[tb/curve25519_field_square_top_tb.sv]
// ----------------------------------------------------------------------------
// curve25519_field_square_top_tb
// Self-checking bench for the pipelined GF(2^255-19) squarer.
// ----------------------------------------------------------------------------
// A queue of operand words feeds a falling-edge driver on the operand
// channel. A rising-edge monitor records every accepted operand and keeps
// the predicted square of it in order. It also compares every accepted
// result word, limb by limb, with the oldest prediction.
// The directed words cover zero, the loose 52-bit bound, the prime and other
// non-canonical limbs. Random words mix full-width limbs with values near
// the limb boundaries. Both channel sides idle at random. There is one
// window without idling, and one long result-side hold-off that backs the
// pipeline up into the operand channel.
// ----------------------------------------------------------------------------
module curve25519_field_square_top_tb import c25519sq_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 2;
    localparam int RST_CYCLES   = 12;
    localparam int RANDOM_WORDS = 1250;
    localparam int DRAIN_CYCLES = 3 * NUM_STG;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 25;
    localparam int CALM_FIRST   = 700;
    localparam int CALM_LAST    = 1000;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 200;

    localparam t_in_limb MAX52 = {IN_W{1'b1}};
    localparam t_in_limb MAX51 = t_in_limb'({LIMB_W{1'b1}});
    localparam t_in_limb TWO51 = t_in_limb'(1) << LIMB_W;

    // 128 bits hold every column sum of the square exactly.
    typedef logic [127:0] t_wide;

    typedef struct packed {
        t_in_limb l0;
        t_in_limb l1;
        t_in_limb l2;
        t_in_limb l3;
        t_in_limb l4;
    } t_operand;

    typedef struct packed {
        t_limb    r0;
        t_limb    r1;
        t_in_limb r2;
        t_limb    r3;
        t_limb    r4;
    } t_square;

    logic i_clk;
    logic i_rst_n;

    c25519sq_in_if  in_ch ();
    c25519sq_out_if out_ch ();

    curve25519_field_square_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_operand operand_q [$];
    t_square  square_q  [$];

    int  words_offered = 0;
    int  words_taken   = 0;
    int  results_seen  = 0;
    int  words_total   = 0;
    int  directed_cnt  = 0;
    int  error_cnt     = 0;
    int  cycle_count   = 0;
    int  hold_left     = 0;
    bit  hold_done     = 1'b0;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Square modulo 2^255-19 with one carry pass and the top carry folded
    // back into limbs 0..2.
    function automatic t_square square_mod_p(t_operand w);
        t_wide       a0, a1, a2, a3, a4;
        t_wide       c0, c1, c2, c3, c4;
        logic [63:0] carry, top, t0, t1, t2;
        t_square     res;
        a0 = t_wide'(w.l0);
        a1 = t_wide'(w.l1);
        a2 = t_wide'(w.l2);
        a3 = t_wide'(w.l3);
        a4 = t_wide'(w.l4);
        c0 = a0 * a0 + a1 * (a4 * 38) + a2 * (a3 * 38);
        c1 = a0 * (a1 * 2) + a2 * (a4 * 38) + a3 * (a3 * 19);
        c2 = a0 * (a2 * 2) + a1 * a1 + a3 * (a4 * 38);
        c3 = a0 * (a3 * 2) + a1 * (a2 * 2) + a4 * (a4 * 19);
        c4 = a0 * (a4 * 2) + a1 * (a3 * 2) + a2 * a2;
        carry = 64'(c0 >> LIMB_W);
        c1 = c1 + t_wide'(carry);
        carry = 64'(c1 >> LIMB_W);
        c2 = c2 + t_wide'(carry);
        carry = 64'(c2 >> LIMB_W);
        c3 = c3 + t_wide'(carry);
        carry = 64'(c3 >> LIMB_W);
        c4 = c4 + t_wide'(carry);
        top = 64'(c4 >> LIMB_W);
        t0 = 64'(c0[LIMB_W-1:0]) + top * 64'd19;
        t1 = (t0 >> LIMB_W) + 64'(c1[LIMB_W-1:0]);
        t2 = (t1 >> LIMB_W) + 64'(c2[LIMB_W-1:0]);
        res.r0 = t0[LIMB_W-1:0];
        res.r1 = t1[LIMB_W-1:0];
        res.r2 = t2[IN_W-1:0];
        res.r3 = c3[LIMB_W-1:0];
        res.r4 = c4[LIMB_W-1:0];
        return res;
    endfunction

    // Random limb, weighted toward zero, the bounds and the 2^51 boundary.
    function automatic t_in_limb pick_limb();
        t_in_limb v;
        v = t_in_limb'({$urandom, $urandom});
        case ($urandom_range(9))
            5: v = MAX52;
            6: v = '0;
            7: v = MAX51 - t_in_limb'($urandom_range(40));
            8: v = t_in_limb'($urandom_range(1000));
            9: v = TWO51 + t_in_limb'($urandom_range(40));
            default: ;
        endcase
        return v;
    endfunction

    task automatic check_limb(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            error_cnt++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
        end
    endtask

    // Operand driver: holds a word until it is taken, then offers the next
    // one unless it chooses to idle.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (words_taken == words_offered) begin
            if (operand_q.size() != 0 &&
                ((words_offered >= CALM_FIRST && words_offered < CALM_LAST) ||
                 $urandom_range(99) >= IDLE_PCT)) begin
                in_ch.limb_in0 <= operand_q[0].l0;
                in_ch.limb_in1 <= operand_q[0].l1;
                in_ch.limb_in2 <= operand_q[0].l2;
                in_ch.limb_in3 <= operand_q[0].l3;
                in_ch.limb_in4 <= operand_q[0].l4;
                in_ch.valid    <= 1'b1;
                void'(operand_q.pop_front());
                words_offered++;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result-side ready: random stalls, a calm window, and one long
    // hold-off counted here while the operand side keeps offering words.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_ch.ready <= 1'b0;
        end else if (results_seen >= CALM_FIRST && results_seen < CALM_LAST) begin
            out_ch.ready <= 1'b1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: predict on every accepted operand word, check every
    // accepted result word against the oldest prediction.
    always @(posedge i_clk) begin
        t_operand w;
        t_square  exp_sq;
        cycle_count++;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                w.l0 = in_ch.limb_in0;
                w.l1 = in_ch.limb_in1;
                w.l2 = in_ch.limb_in2;
                w.l3 = in_ch.limb_in3;
                w.l4 = in_ch.limb_in4;
                square_q.push_back(square_mod_p(w));
                words_taken++;
            end
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (square_q.size() == 0) begin
                    error_cnt++;
                    $display("%0t ns: extra result, expected none, actual %0h %0h %0h %0h %0h",
                             $time, out_ch.limb_out0, out_ch.limb_out1,
                             out_ch.limb_out2, out_ch.limb_out3, out_ch.limb_out4);
                end else begin
                    exp_sq = square_q.pop_front();
                    check_limb("limb_out0", 64'(exp_sq.r0), 64'(out_ch.limb_out0));
                    check_limb("limb_out1", 64'(exp_sq.r1), 64'(out_ch.limb_out1));
                    check_limb("limb_out2", 64'(exp_sq.r2), 64'(out_ch.limb_out2));
                    check_limb("limb_out3", 64'(exp_sq.r3), 64'(out_ch.limb_out3));
                    check_limb("limb_out4", 64'(exp_sq.r4), 64'(out_ch.limb_out4));
                end
            end
        end
    end

    // Watchdog on the cycle counter.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d results pending",
                 cycle_count, square_q.size());
        $display("FAIL curve25519_field_square_top");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial begin
        t_operand w;
        in_ch.valid    = 1'b0;
        in_ch.limb_in0 = '0;
        in_ch.limb_in1 = '0;
        in_ch.limb_in2 = '0;
        in_ch.limb_in3 = '0;
        in_ch.limb_in4 = '0;
        out_ch.ready   = 1'b0;
        i_rst_n        = 1'b0;

        // Directed words: zero, the loose bound, all-ones 51-bit limbs, the prime
        // itself, limbs of exactly 2^51, one heavy limb at a time, patterns.
        operand_q.push_back('{'0, '0, '0, '0, '0});
        operand_q.push_back('{t_in_limb'(1), '0, '0, '0, '0});
        operand_q.push_back('{MAX52, MAX52, MAX52, MAX52, MAX52});
        operand_q.push_back('{MAX51, MAX51, MAX51, MAX51, MAX51});
        operand_q.push_back('{MAX51 - 18, MAX51, MAX51, MAX51, MAX51});
        operand_q.push_back('{MAX52 - 37, MAX52, MAX52, MAX52, MAX52});
        operand_q.push_back('{MAX51 - 17, MAX51, MAX51, MAX51, MAX51});
        operand_q.push_back('{TWO51, TWO51, TWO51, TWO51, TWO51});
        for (int i = 0; i < NUM_LIMBS; i++) begin
            w = '0;
            case (i)
                0: w.l0 = MAX52;
                1: w.l1 = MAX52;
                2: w.l2 = MAX52;
                3: w.l3 = MAX52;
                default: w.l4 = MAX52;
            endcase
            operand_q.push_back(w);
        end
        operand_q.push_back('{t_in_limb'(1), t_in_limb'(1), t_in_limb'(1),
                              t_in_limb'(1), t_in_limb'(1)});
        operand_q.push_back('{{26{2'b10}}, {26{2'b10}}, {26{2'b10}},
                              {26{2'b10}}, {26{2'b10}}});
        operand_q.push_back('{{26{2'b01}}, {26{2'b01}}, {26{2'b01}},
                              {26{2'b01}}, {26{2'b01}}});
        operand_q.push_back('{MAX52, '0, MAX52, '0, MAX52});
        operand_q.push_back('{'0, MAX52, '0, MAX52, '0});
        operand_q.push_back('{MAX51, TWO51, MAX51, TWO51, MAX51});
        operand_q.push_back('{'0, '0, '0, '0, t_in_limb'(1)});
        directed_cnt = operand_q.size();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            w.l0 = pick_limb();
            w.l1 = pick_limb();
            w.l2 = pick_limb();
            w.l3 = pick_limb();
            w.l4 = pick_limb();
            operand_q.push_back(w);
        end
        words_total = operand_q.size();

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (words_taken == words_total);
        wait (square_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Squared %0d operand words (%0d directed, %0d random), %0d results",
                 words_taken, directed_cnt, words_total - directed_cnt, results_seen);
        $display("Idling on both sides, a calm stretch and a %0d-cycle stall; %0d mismatches",
                 HOLD_CYCLES, error_cnt);
        if (error_cnt == 0 && square_q.size() == 0) begin
            $display("PASS curve25519_field_square_top");
        end else begin
            $display("FAIL curve25519_field_square_top");
        end
        $finish;
    end

endmodule
